[sv/cpo_pkg.sv]
// Shared types and widths for the convex polygon overlap test core.
`default_nettype none

package cpo_pkg;

	// Default vertex capacity per polygon
	localparam int MAX_VERTICES_DEF = 16;

	// Exact arithmetic widths
	localparam int IN_W    = 16; // input coordinate
	localparam int COORD_W = 17; // vertex plus position offset
	localparam int AXIS_W  = 18; // edge component / axis component
	localparam int PROD_W  = 35; // axis * coordinate
	localparam int DOT_W   = 36; // sum of two products
	localparam int GAP_W   = 37; // difference of two projections

	// Input item: one vertex
	typedef struct packed {
		logic              poly_id;
		logic signed [IN_W-1:0] vertex_x;
		logic signed [IN_W-1:0] vertex_y;
		logic signed [IN_W-1:0] pos_x;
		logic signed [IN_W-1:0] pos_y;
		logic              last_vertex;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic intersecting;
		logic overflow;
	} out_item_t;

	// Stored vertex, absolute coordinates
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} vertex_t;

endpackage

`default_nettype wire

[sv/cpo_vstore.sv]
// Vertex memory: one write port, one registered read port.
`default_nettype none

module cpo_vstore #(
	parameter int DEPTH = 2 * cpo_pkg::MAX_VERTICES_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire cpo_pkg::vertex_t wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output cpo_pkg::vertex_t      rdata
);

	cpo_pkg::vertex_t mem_q [DEPTH];
	cpo_pkg::vertex_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[sv/cpo_mul.sv]
// Shared signed multiplier with registered product.
`default_nettype none

module cpo_mul (
	input  wire logic                                 clk,
	input  wire logic signed [cpo_pkg::AXIS_W-1:0]  a,
	input  wire logic signed [cpo_pkg::COORD_W-1:0] b,
	output logic signed [cpo_pkg::PROD_W-1:0]       p
);

	logic signed [cpo_pkg::PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= cpo_pkg::PROD_W'(a) * cpo_pkg::PROD_W'(b);
	end

	assign p = p_q;

endmodule

`default_nettype wire

[sv/convex_polygon_overlap_test_core.sv]
// Top level: vertex loading and the separating-axis sequencer.
//
// Vertices are taken one per cycle while the core is idle; each is offset by
// its polygon position and stored while its polygon has room. The B vertex
// marked last starts the test and the core is busy until the result is
// registered. For every edge of A, then of B, the sequencer forms the edge
// normal (states EI, EJ, EC), then for each stored vertex of both polygons
// makes one memory read, two passes through the single shared multiplier and
// one min/max update, then checks the gap. The test stops at the first
// separating axis. An empty polygon A goes straight to the hand-over state.
// The single read port of the vertex memory and the one multiplier set this
// order of steps.
`default_nettype none

module convex_polygon_overlap_test_core #(
	parameter int MAX_VERTICES = cpo_pkg::MAX_VERTICES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire cpo_pkg::in_item_t  in_item,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output cpo_pkg::out_item_t      out_item
);

	localparam int DEPTH = 2 * MAX_VERTICES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(MAX_VERTICES + 1);
	localparam logic [CW-1:0] MAX_C  = CW'(MAX_VERTICES);
	localparam logic [AW-1:0] BASE_B = AW'(MAX_VERTICES);

	localparam int COORD_W = cpo_pkg::COORD_W;
	localparam int AXIS_W  = cpo_pkg::AXIS_W;
	localparam int PROD_W  = cpo_pkg::PROD_W;
	localparam int DOT_W   = cpo_pkg::DOT_W;
	localparam int GAP_W   = cpo_pkg::GAP_W;

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_EI   = 4'd1; // read edge start vertex
	localparam logic [3:0] S_EJ   = 4'd2; // read edge end vertex
	localparam logic [3:0] S_EC   = 4'd3; // form normal
	localparam logic [3:0] S_PRD  = 4'd4; // read projected vertex
	localparam logic [3:0] S_PM1  = 4'd5; // multiply x
	localparam logic [3:0] S_PM2  = 4'd6; // multiply y
	localparam logic [3:0] S_PACC = 4'd7; // sum, min/max
	localparam logic [3:0] S_GAP  = 4'd8; // gap check
	localparam logic [3:0] S_FIN  = 4'd9; // hand over result

	logic [3:0]    state_q;
	logic [CW-1:0] cnt_a_q, cnt_b_q;
	logic          ovf_seen_q;
	logic          p_e_q, q_q;
	logic [CW-1:0] i_e_q, v_q;
	logic          res_q, ovf_res_q;
	logic          out_valid_q;
	cpo_pkg::out_item_t out_item_q;

	logic signed [COORD_W-1:0] xi_q, yi_q;
	logic signed [AXIS_W-1:0]  ax_q, ay_q;
	logic signed [PROD_W-1:0]  p1_q;
	logic signed [DOT_W-1:0]   lo_q, hi_q, min_a_q, max_a_q;

	// input side
	logic          acc_in;
	logic [CW-1:0] cnt_sel;
	logic          room;
	logic          start;
	cpo_pkg::vertex_t wdata;
	logic [AW-1:0] waddr;

	assign in_ready = (state_q == S_IDLE);
	assign acc_in   = in_valid && in_ready;
	assign cnt_sel  = in_item.poly_id ? cnt_b_q : cnt_a_q;
	assign room     = (cnt_sel < MAX_C);
	assign start    = acc_in && in_item.poly_id && in_item.last_vertex;
	assign wdata.x  = COORD_W'(in_item.vertex_x) + COORD_W'(in_item.pos_x);
	assign wdata.y  = COORD_W'(in_item.vertex_y) + COORD_W'(in_item.pos_y);
	assign waddr    = AW'(cnt_sel) + (in_item.poly_id ? BASE_B : AW'(0));

	// test side
	logic [CW-1:0] n_e, n_q, j_e;
	logic          rd_en;
	logic [AW-1:0] raddr;
	cpo_pkg::vertex_t rdata;

	assign n_e = p_e_q ? cnt_b_q : cnt_a_q;
	assign n_q = q_q ? cnt_b_q : cnt_a_q;
	assign j_e = (CW'(i_e_q + 1'b1) == n_e) ? CW'(0) : CW'(i_e_q + 1'b1);

	// read address per state
	always_comb begin
		rd_en = 1'b0;
		raddr = AW'(0);
		case (state_q)
			S_EI: begin
				rd_en = 1'b1;
				raddr = AW'(i_e_q) + (p_e_q ? BASE_B : AW'(0));
			end
			S_EJ: begin
				rd_en = 1'b1;
				raddr = AW'(j_e) + (p_e_q ? BASE_B : AW'(0));
			end
			S_PRD: begin
				rd_en = 1'b1;
				raddr = AW'(v_q) + (q_q ? BASE_B : AW'(0));
			end
			default: begin
				rd_en = 1'b0;
				raddr = AW'(0);
			end
		endcase
	end

	cpo_vstore #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_vstore (
		.clk   (clk),
		.we    (acc_in && room),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	// shared multiplier: x term in PM1, y term in PM2
	logic signed [AXIS_W-1:0]  mul_a;
	logic signed [COORD_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_p;

	assign mul_a = (state_q == S_PM1) ? ax_q : ay_q;
	assign mul_b = (state_q == S_PM1) ? rdata.x : rdata.y;

	cpo_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// projection and running min/max
	logic signed [DOT_W-1:0] dot, new_lo, new_hi;
	logic signed [GAP_W-1:0] gap;
	logic                    last_v;

	assign dot    = DOT_W'(p1_q) + DOT_W'(mul_p);
	assign new_lo = ((v_q == CW'(0)) || (dot < lo_q)) ? dot : lo_q;
	assign new_hi = ((v_q == CW'(0)) || (dot > hi_q)) ? dot : hi_q;
	assign last_v = (CW'(v_q + 1'b1) == n_q);
	assign gap    = (min_a_q < lo_q) ? (GAP_W'(lo_q) - GAP_W'(max_a_q))
	                                 : (GAP_W'(min_a_q) - GAP_W'(hi_q));

	// normal of the edge i -> j: (-(yj - yi), xj - xi)
	logic signed [AXIS_W-1:0] ex, ey;

	assign ex = AXIS_W'(rdata.x) - AXIS_W'(xi_q);
	assign ey = AXIS_W'(rdata.y) - AXIS_W'(yi_q);

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_EJ) begin
			xi_q <= rdata.x;
			yi_q <= rdata.y;
		end
		if (state_q == S_EC) begin
			ax_q <= -ey;
			ay_q <= ex;
		end
		if (state_q == S_PM2) begin
			p1_q <= mul_p;
		end
		if (state_q == S_PACC) begin
			lo_q <= new_lo;
			hi_q <= new_hi;
			if (!q_q && last_v) begin
				min_a_q <= new_lo;
				max_a_q <= new_hi;
			end
		end
		if (state_q == S_FIN && (!out_valid_q || out_ready)) begin
			out_item_q.intersecting <= res_q;
			out_item_q.overflow     <= ovf_res_q;
		end
	end

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			ovf_seen_q  <= 1'b0;
			p_e_q       <= 1'b0;
			i_e_q       <= '0;
			q_q         <= 1'b0;
			v_q         <= '0;
			res_q       <= 1'b0;
			ovf_res_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// hand-over state drives valid on its own
			if (out_valid_q && out_ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc_in) begin
						if (room) begin
							if (in_item.poly_id) begin
								cnt_b_q <= CW'(cnt_b_q + 1'b1);
							end else begin
								cnt_a_q <= CW'(cnt_a_q + 1'b1);
							end
						end else begin
							ovf_seen_q <= 1'b1;
						end
					end
					if (start) begin
						ovf_res_q <= ovf_seen_q || !room;
						p_e_q     <= 1'b0;
						i_e_q     <= '0;
						if (cnt_a_q == CW'(0)) begin
							res_q   <= 1'b0;
							state_q <= S_FIN;
						end else begin
							state_q <= S_EI;
						end
					end
				end
				S_EI: begin
					state_q <= S_EJ;
				end
				S_EJ: begin
					state_q <= S_EC;
				end
				S_EC: begin
					q_q     <= 1'b0;
					v_q     <= '0;
					state_q <= S_PRD;
				end
				S_PRD: begin
					state_q <= S_PM1;
				end
				S_PM1: begin
					state_q <= S_PM2;
				end
				S_PM2: begin
					state_q <= S_PACC;
				end
				S_PACC: begin
					if (!last_v) begin
						v_q     <= CW'(v_q + 1'b1);
						state_q <= S_PRD;
					end else if (!q_q) begin
						q_q     <= 1'b1;
						v_q     <= '0;
						state_q <= S_PRD;
					end else begin
						state_q <= S_GAP;
					end
				end
				S_GAP: begin
					if (!gap[GAP_W-1]) begin
						// gap or touching contact: separated
						res_q   <= 1'b0;
						state_q <= S_FIN;
					end else if (CW'(i_e_q + 1'b1) != n_e) begin
						i_e_q   <= CW'(i_e_q + 1'b1);
						state_q <= S_EI;
					end else if (!p_e_q) begin
						p_e_q   <= 1'b1;
						i_e_q   <= '0;
						state_q <= S_EI;
					end else begin
						res_q   <= 1'b1;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						cnt_a_q     <= '0;
						cnt_b_q     <= '0;
						ovf_seen_q  <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_a_q <= MAX_C) && (cnt_b_q <= MAX_C))
		else $error("vertex count beyond capacity");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !in_ready)
		else $error("core still ready after test start");

	a_edge_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EI) |-> (i_e_q < n_e))
		else $error("edge index outside stored polygon");

	a_proj_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PRD) |-> (v_q < n_q))
		else $error("projected vertex outside stored polygon");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_FIN))
		else $error("result raised outside hand-over state");

endmodule

`default_nettype wire

[tb/convex_polygon_overlap_test_core_tb.sv]
// Testbench for the convex polygon overlap test core.
`default_nettype none

module convex_polygon_overlap_test_core_tb;

	localparam int NV     = cpo_pkg::MAX_VERTICES_DEF;
	localparam int N_DIRS = 16;

	// Directions around a near-circle, in angular order; any ordered subset stays convex
	localparam int DIR_X [N_DIRS] = '{8, 7, 6, 3, 0, -3, -6, -7, -8, -7, -6, -3, 0, 3, 6, 7};
	localparam int DIR_Y [N_DIRS] = '{0, 3, 6, 7, 8, 7, 6, 3, 0, -3, -6, -7, -8, -7, -6, -3};

	typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	typedef struct {
		cpo_pkg::in_item_t v;
		bit                drain; // hold this item until all verdicts are in
	} pending_vertex_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	cpo_pkg::in_item_t  in_item   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	cpo_pkg::out_item_t out_item;

	pending_vertex_t    vertex_q[$];
	cpo_pkg::out_item_t verdict_q[$];
	bit                 drain_req = 1'b0;

	// Predictor state: absolute vertices per polygon, counts, sticky drop flag
	longint poly_x [2][NV];
	longint poly_y [2][NV];
	int     poly_cnt [2] = '{0, 0};
	bit     drop_seen = 1'b0;

	int n_errors     = 0;
	int n_accepted   = 0;
	int n_results    = 0;
	int n_tests      = 0;
	int n_overlaps   = 0;
	int n_overflowed = 0;

	int       burst_left = 0;
	int       gap_left   = 0;
	int       rx_cycle   = 0;
	int       hold_left  = 0;
	rx_mode_t rx_mode    = RX_FREE;

	convex_polygon_overlap_test_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic flag_mismatch(input string what, input int got, input int want);
		n_errors++;
		$display("mismatch on result %0d: %s got %0d want %0d", n_results, what, got, want);
	endtask

	// Separating axis search over every edge normal of A, then of B
	function automatic bit axes_overlap();
		int     na, nb, k, p, i, j, q, m;
		longint ax, ay, d, gap;
		longint lo [2];
		longint hi [2];
		na = poly_cnt[0];
		nb = poly_cnt[1];
		if (na == 0 || nb == 0)
			return 1'b0;
		for (k = 0; k < na + nb; k++) begin
			p  = (k < na) ? 0 : 1;
			i  = p ? k - na : k;
			j  = (i + 1 == poly_cnt[p]) ? 0 : i + 1;
			ax = -(poly_y[p][j] - poly_y[p][i]);
			ay = poly_x[p][j] - poly_x[p][i];
			for (q = 0; q < 2; q++) begin
				for (m = 0; m < poly_cnt[q]; m++) begin
					d = ax * poly_x[q][m] + ay * poly_y[q][m];
					if (m == 0 || d < lo[q]) lo[q] = d;
					if (m == 0 || d > hi[q]) hi[q] = d;
				end
			end
			gap = (lo[0] < lo[1]) ? lo[1] - hi[0] : lo[0] - hi[1];
			// a gap or touching contact separates
			if (gap >= 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Store one accepted vertex; the last B vertex yields a verdict
	task automatic load_vertex(input cpo_pkg::in_item_t v);
		int                 p;
		cpo_pkg::out_item_t res;
		p = int'(v.poly_id);
		if (poly_cnt[p] < NV) begin
			poly_x[p][poly_cnt[p]] = longint'($signed(v.vertex_x)) + longint'($signed(v.pos_x));
			poly_y[p][poly_cnt[p]] = longint'($signed(v.vertex_y)) + longint'($signed(v.pos_y));
			poly_cnt[p]++;
		end else begin
			drop_seen = 1'b1;
		end
		if (v.poly_id && v.last_vertex) begin
			res.intersecting = axes_overlap();
			res.overflow     = drop_seen;
			verdict_q.push_back(res);
			n_tests++;
			if (res.intersecting) n_overlaps++;
			if (res.overflow) n_overflowed++;
			poly_cnt[0] = 0;
			poly_cnt[1] = 0;
			drop_seen   = 1'b0;
		end
	endtask

	task automatic push_vertex(input bit pid, input int vx, input int vy, input int px,
			input int py, input bit last);
		pending_vertex_t pv;
		pv.v.poly_id     = pid;
		pv.v.vertex_x    = 16'(vx);
		pv.v.vertex_y    = 16'(vy);
		pv.v.pos_x       = 16'(px);
		pv.v.pos_y       = 16'(py);
		pv.v.last_vertex = last;
		pv.drain         = drain_req;
		drain_req        = 1'b0;
		vertex_q.push_back(pv);
	endtask

	// Convex polygon of n vertices around (cx, cy); beyond 16 the walk wraps
	task automatic push_polygon(input bit pid, input int cx, input int cy, input int r,
			input int n, input bit mark_last);
		int k, start, step_n, idx;
		start  = $urandom_range(0, N_DIRS - 1);
		step_n = (n > N_DIRS) ? N_DIRS : n;
		for (k = 0; k < n; k++) begin
			idx = (start + (k * N_DIRS) / step_n) % N_DIRS;
			push_vertex(pid, r * DIR_X[idx], r * DIR_Y[idx], cx, cy, mark_last && k == n - 1);
		end
	endtask

	function automatic int pick_size();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 8);
	endfunction

	// Sender: bursts with gaps; valid holds until the item is taken
	always @(posedge clk or negedge arst_n) begin : sender
		pending_vertex_t pv;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				load_vertex(in_item);
				n_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (vertex_q.size() > 0 &&
						!(vertex_q[0].drain && verdict_q.size() > 0)) begin
					pv = vertex_q.pop_front();
					in_valid <= 1'b1;
					in_item  <= pv.v;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = ($urandom_range(0, 4) == 0) ?
							$urandom_range(20, 60) : $urandom_range(1, 10);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks verdicts in order and stalls on a shifting pattern
	always @(posedge clk or negedge arst_n) begin : receiver
		cpo_pkg::out_item_t want;
		bit                 rdy;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			rx_cycle++;
			if (out_valid && out_ready) begin
				n_results++;
				if (verdict_q.size() == 0) begin
					flag_mismatch("result with none pending", int'(out_item), -1);
				end else begin
					want = verdict_q.pop_front();
					if (out_item.intersecting !== want.intersecting)
						flag_mismatch("intersecting", int'(out_item.intersecting),
							int'(want.intersecting));
					if (out_item.overflow !== want.overflow)
						flag_mismatch("overflow", int'(out_item.overflow),
							int'(want.overflow));
				end
				// long hold-off so the core backs up into its input
				if (n_results == 8 || n_results == 30)
					hold_left = 300;
			end
			if (rx_cycle % 50 == 0)
				rx_mode = rx_mode_t'($urandom_range(0, 3));
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				case (rx_mode)
					RX_FREE:   rdy = 1'b1;
					RX_COIN:   rdy = 1'($urandom_range(0, 1));
					RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
					default:   rdy = (rx_cycle % 7) >= 2;
				endcase
			end
			out_ready <= rdy;
		end
	end

	initial begin : stimulus
		int kind, na, nb, ra, rb, cax, cay, cbx, cby, span, k, n;
		bit mid_drain, pid;
		mid_drain = 1'b0;

		// Overlapping triangles; A's last flag sits mid-polygon and more A follows
		push_vertex(1'b0, 0, 0, 0, 0, 1'b0);
		push_vertex(1'b0, 10, 0, 0, 0, 1'b1);
		push_vertex(1'b0, 0, 10, 0, 0, 1'b0);
		push_vertex(1'b1, 0, 0, 2, 2, 1'b0);
		push_vertex(1'b1, 10, 0, 2, 2, 1'b0);
		push_vertex(1'b1, 0, 10, 2, 2, 1'b1);
		// Triangles touching at one corner
		push_vertex(1'b0, 0, 0, 0, 0, 1'b0);
		push_vertex(1'b0, 10, 0, 0, 0, 1'b0);
		push_vertex(1'b0, 0, 10, 0, 0, 1'b1);
		push_vertex(1'b1, 0, 0, 10, 0, 1'b0);
		push_vertex(1'b1, 10, 0, 10, 0, 1'b0);
		push_vertex(1'b1, 0, 10, 10, 0, 1'b1);
		// Empty A
		push_vertex(1'b1, 3, -3, 0, 0, 1'b1);
		// Single vertex each: zero-length edge
		push_vertex(1'b0, 5, 5, 0, 0, 1'b1);
		push_vertex(1'b1, 5, 5, 0, 0, 1'b1);
		// Coordinate extremes around a small triangle
		push_vertex(1'b0, -32768, -32768, -32768, -32768, 1'b0);
		push_vertex(1'b0, 32767, -32768, 32767, -32768, 1'b0);
		push_vertex(1'b0, -32768, 32767, -32768, 32767, 1'b1);
		push_vertex(1'b1, 32767, -32767, -32767, 32767, 1'b0);
		push_vertex(1'b1, 1, 0, 0, 0, 1'b0);
		push_vertex(1'b1, 0, 1, 0, 0, 1'b1);

		// Random part starts once the directed verdicts are all in
		drain_req = 1'b1;
		while (vertex_q.size() < 450) begin
			if (!mid_drain && vertex_q.size() >= 250) begin
				drain_req = 1'b1;
				mid_drain = 1'b1;
			end
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				// well-formed pair of convex polygons, near enough to go either way
				na   = pick_size();
				nb   = pick_size();
				ra   = $urandom_range(1, 1200);
				rb   = $urandom_range(1, 1200);
				cax  = int'($urandom_range(0, 10000)) - 5000;
				cay  = int'($urandom_range(0, 10000)) - 5000;
				span = (ra + rb) * 8;
				cbx  = cax + int'($urandom_range(0, 2 * span)) - span;
				cby  = cay + int'($urandom_range(0, 2 * span)) - span;
				if ($urandom_range(0, 19) != 0) begin
					push_polygon(1'b0, cax, cay, ra, na, 1'b1);
					if ($urandom_range(0, 9) == 0)
						push_polygon(1'b0, cax, cay, ra / 2 + 1, $urandom_range(1, 3), 1'b0);
				end
				push_polygon(1'b1, cbx, cby, rb, nb, 1'b1);
			end else if (kind < 85) begin
				// full-range noise
				n = $urandom_range(1, 6);
				for (k = 0; k < n; k++)
					push_vertex(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
						$urandom, $urandom_range(0, 3) == 0);
			end else begin
				// A and B vertices interleaved, closed by a last B vertex
				n = $urandom_range(2, 10);
				for (k = 0; k < n; k++) begin
					pid = (k == n - 1) ? 1'b1 : 1'($urandom_range(0, 1));
					push_vertex(pid, int'($urandom_range(0, 6000)) - 3000,
						int'($urandom_range(0, 6000)) - 3000,
						int'($urandom_range(0, 6000)) - 3000,
						int'($urandom_range(0, 6000)) - 3000,
						(k == n - 1) || (!pid && $urandom_range(0, 4) == 0));
				end
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (vertex_q.size() > 0 || in_valid)
			@(posedge clk);
		while (verdict_q.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("covered %0d vertices and %0d overlap tests: %0d intersecting, %0d with drops",
			n_accepted, n_tests, n_overlaps, n_overflowed);
		$display("output held off for long stretches twice; %0d mismatches", n_errors);
		if (n_errors == 0 && verdict_q.size() == 0) begin
			$display("convex_polygon_overlap_test_core_tb: PASS");
		end else begin
			$display("convex_polygon_overlap_test_core_tb: FAIL");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("convex_polygon_overlap_test_core_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
